>>> src/srs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Selective-repeat sender package
// Shared types, codes and default constants for the sender block.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int DEF_MAX_SEQ    = 256;
    localparam int DEF_MAX_WINDOW = 8;

    localparam int TOTAL_W   = 9;
    localparam int WINDOW_W  = 4;
    localparam int SEQ_W     = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [TOTAL_W-1:0]  TOTAL_FRAMES_RST = 9'd10;
    localparam logic [WINDOW_W-1:0] WIN_LEN_RST      = 4'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN      = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_TIMEOUT = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACK_CHK,
        ST_SLIDE_RD,
        ST_SLIDE_CHK,
        ST_TO_RD,
        ST_TO_CHK,
        ST_SEND_SETUP,
        ST_SEND,
        ST_DRAIN_RD,
        ST_DRAIN_LD
    } state_t;

    // One buffered result item, before the per-event flags are attached.
    typedef struct packed {
        logic             frame_valid;
        logic             is_retransmit;
        logic [SEQ_W-1:0] frame_seq;
    } item_t;

endpackage
`default_nettype wire

>>> src/srs_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared step unit
// One compare and one increment, reused by every walk of the sequencer.
// ----------------------------------------------------------------------------
module srs_step_unit #(
    parameter int W = 9
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              lt,
    output logic [W-1:0]      inc
);
    assign lt  = a < b;
    assign inc = a + W'(1);
endmodule
`default_nettype wire

>>> src/srs_bitmap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Acknowledged bitmap
// One bit per sequence number, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srs_bitmap #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_bit,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_bit
);
    logic mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
        rd_bit <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> src/srs_item_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result item buffer
// Holds the items of one event until the event is complete and can be drained.
// ----------------------------------------------------------------------------
module srs_item_buf #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic           aclk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire srs_pkg::item_t wr_item,
    input  wire logic [AW-1:0]  rd_addr,
    output srs_pkg::item_t      rd_item
);
    import srs_pkg::*;

    item_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_item;
        end
        rd_item <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> src/selective_repeat_sender_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Selective-repeat ARQ sender
// Tracks the send window and acknowledged frames and emits the frames to send.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one event: start, acknowledgement of
// s_ack_seq, or timeout. The block answers with one to MAX_WINDOW result
// requests on the m_ channel, the final one marked by m_last. An event that
// sends no frame yields a single status request with m_frame_valid low.
// The cfg_ channel writes the frame total (index 0) and the window length
// (index 1). It is ready only while the sequencer is idle, and a pending write
// holds off s_ready, so a new value applies from the next event on.
//
// Sequence: an event is accepted in the idle state and an acknowledgement is
// checked; the base then slides past acknowledged frames through a read and
// a check state per frame, and a timeout walks the frames it inspects the
// same way. The send loop is then set up, new frames are written to the item
// buffer, and each result request is drained through a read and a load
// state. s_ready is high only while the sequencer is idle.
//
// After reset the bitmap is cleared by a pass over all MAX_SEQ entries, during
// which no event is accepted. If the receiver stalls, the drain waits in its
// load state. The last result waits in the output register; the next event is
// still accepted, and its results wait until the register is free.
// ----------------------------------------------------------------------------
module selective_repeat_sender_unit #(
    parameter int MAX_SEQ    = srs_pkg::DEF_MAX_SEQ,
    parameter int MAX_WINDOW = srs_pkg::DEF_MAX_WINDOW
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Event channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [srs_pkg::MODE_W-1:0]    s_mode,
    input  wire logic [srs_pkg::SEQ_W-1:0]     s_ack_seq,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [srs_pkg::SEQ_W-1:0]          m_frame_seq,
    output logic                               m_frame_valid,
    output logic                               m_is_retransmit,
    output logic                               m_last,
    output logic                               m_all_done,
    output logic                               m_ack_ignored,
    // Configuration channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srs_pkg::CFG_DAT_W-1:0] cfg_data
);
    import srs_pkg::*;

    // Counter widths: sequence counters must hold MAX_SEQ itself.
    localparam int IDX_W  = $clog2(MAX_SEQ);
    localparam int CNT_W  = $clog2(MAX_SEQ + 1);
    localparam int UW     = (CNT_W > SEQ_W) ? CNT_W : SEQ_W;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int NW     = WIN_W;
    localparam int BUF_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int TCW    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int WCW    = (WIN_W > WINDOW_W) ? WIN_W : WINDOW_W;
    localparam int SUM_W  = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;

    state_t state_reg, state_next;

    logic [TOTAL_W-1:0]  total_frames_reg;
    logic [WINDOW_W-1:0] win_len_reg;

    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] next_reg, next_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [SEQ_W-1:0] ack_reg, ack_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [NW-1:0]    rd_idx_reg, rd_idx_next;
    logic             ignored_reg, ignored_next;
    logic             done_reg, done_next;

    logic             m_valid_reg, m_valid_next;
    item_t            m_item_reg, m_item_next;
    logic             m_last_reg, m_last_next;
    logic             m_done_reg, m_done_next;
    logic             m_ign_reg, m_ign_next;

    // Saturated configuration values.
    logic [TCW-1:0]   tot_ext;
    logic [CNT_W-1:0] tot_eff;
    logic [WCW-1:0]   win_ext;
    logic [WIN_W-1:0] win_eff;
    logic [SUM_W-1:0] win_sum;

    assign tot_ext = TCW'(total_frames_reg);
    assign tot_eff = (tot_ext > TCW'(MAX_SEQ)) ? CNT_W'(MAX_SEQ) : CNT_W'(tot_ext);
    assign win_ext = WCW'(win_len_reg);
    assign win_eff = (win_ext > WCW'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(win_ext);
    assign win_sum = SUM_W'(base_reg) + SUM_W'(win_eff);

    // Shared step unit, operands chosen by the sequencer state.
    logic [UW-1:0] unit_a, unit_b, unit_inc;
    logic          unit_lt;

    srs_step_unit #(.W(UW)) u_step (
        .a   (unit_a),
        .b   (unit_b),
        .lt  (unit_lt),
        .inc (unit_inc)
    );

    // Bitmap and item buffer ports.
    logic             bm_wr_en, bm_wr_bit, bm_rd_bit;
    logic [IDX_W-1:0] bm_wr_addr, bm_rd_addr;
    logic             buf_wr_en;
    logic [BUF_AW-1:0] buf_wr_addr;
    item_t            buf_wr_item, buf_rd_item;

    srs_bitmap #(.DEPTH(MAX_SEQ), .AW(IDX_W)) u_bitmap (
        .aclk    (aclk),
        .wr_en   (bm_wr_en),
        .wr_addr (bm_wr_addr),
        .wr_bit  (bm_wr_bit),
        .rd_addr (bm_rd_addr),
        .rd_bit  (bm_rd_bit)
    );

    srs_item_buf #(.DEPTH(MAX_WINDOW), .AW(BUF_AW)) u_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_item (buf_wr_item),
        .rd_addr (rd_idx_reg[BUF_AW-1:0]),
        .rd_item (buf_rd_item)
    );

    // The walk loops read the bitmap at the cursor on a timeout and at the
    // base otherwise; the registered data is there in the following check state.
    assign bm_rd_addr  = (state_reg == ST_TO_RD) ? cur_reg[IDX_W-1:0] : base_reg[IDX_W-1:0];
    assign buf_wr_addr = n_reg[BUF_AW-1:0];

    // Configuration registers, writable only between events.
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_frames_reg <= TOTAL_FRAMES_RST;
            win_len_reg      <= WIN_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_TOTAL_FRAMES: total_frames_reg <= cfg_data[TOTAL_W-1:0];
                REG_WIN_LEN:      win_len_reg      <= cfg_data[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state register and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            base_reg    <= '0;
            next_reg    <= '0;
            cur_reg     <= '0;
            n_reg       <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            next_reg    <= next_next;
            cur_reg     <= cur_next;
            n_reg       <= n_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        lim_reg     <= lim_next;
        ack_reg     <= ack_next;
        ignored_reg <= ignored_next;
        done_reg    <= done_next;
        m_item_reg  <= m_item_next;
        m_last_reg  <= m_last_next;
        m_done_reg  <= m_done_next;
        m_ign_reg   <= m_ign_next;
    end

    logic n_full;
    logic m_free;
    assign n_full = (n_reg == NW'(MAX_WINDOW));
    assign m_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        next_next    = next_reg;
        cur_next     = cur_reg;
        lim_next     = lim_reg;
        ack_next     = ack_reg;
        n_next       = n_reg;
        rd_idx_next  = rd_idx_reg;
        ignored_next = ignored_reg;
        done_next    = done_reg;

        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;
        m_ign_next   = m_ign_reg;

        unit_a      = '0;
        unit_b      = '0;
        s_ready     = 1'b0;
        bm_wr_en    = 1'b0;
        bm_wr_addr  = cur_reg[IDX_W-1:0];
        bm_wr_bit   = 1'b0;
        buf_wr_en   = 1'b0;
        buf_wr_item = '0;

        case (state_reg)
            ST_CLEAR: begin
                // Clearing pass: one bitmap entry per cycle after reset.
                unit_a     = UW'(cur_reg);
                unit_b     = UW'(MAX_SEQ - 1);
                bm_wr_en   = 1'b1;
                bm_wr_bit  = 1'b0;
                cur_next   = CNT_W'(unit_inc);
                if (!unit_lt) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // A register write in the same cycle goes first.
                s_ready = !cfg_valid;
                if (s_valid && !cfg_valid) begin
                    ack_next     = s_ack_seq;
                    n_next       = '0;
                    ignored_next = 1'b0;
                    cur_next     = base_reg;
                    case (s_mode)
                        MODE_ACK:     state_next = ST_ACK_CHK;
                        MODE_TIMEOUT: state_next = ST_TO_RD;
                        default:      state_next = ST_SEND_SETUP;
                    endcase
                end
            end
            ST_ACK_CHK: begin
                // Only frames already sent can be acknowledged.
                unit_a = UW'(ack_reg);
                unit_b = UW'(next_reg);
                if (unit_lt) begin
                    bm_wr_en   = 1'b1;
                    bm_wr_addr = IDX_W'(ack_reg);
                    bm_wr_bit  = 1'b1;
                    state_next = ST_SLIDE_RD;
                end else begin
                    ignored_next = 1'b1;
                    state_next   = ST_SEND_SETUP;
                end
            end
            ST_SLIDE_RD: begin
                // The bound is checked before the bitmap entry is looked at.
                unit_a = UW'(base_reg);
                unit_b = UW'(tot_eff);
                if (unit_lt) begin
                    state_next = ST_SLIDE_CHK;
                end else begin
                    state_next = ST_SEND_SETUP;
                end
            end
            ST_SLIDE_CHK: begin
                unit_a = UW'(base_reg);
                if (bm_rd_bit) begin
                    base_next  = CNT_W'(unit_inc);
                    state_next = ST_SLIDE_RD;
                end else begin
                    state_next = ST_SEND_SETUP;
                end
            end
            ST_TO_RD: begin
                unit_a = UW'(cur_reg);
                unit_b = UW'(next_reg);
                if (unit_lt && !n_full) begin
                    state_next = ST_TO_CHK;
                end else begin
                    state_next = ST_SEND_SETUP;
                end
            end
            ST_TO_CHK: begin
                unit_a   = UW'(cur_reg);
                cur_next = CNT_W'(unit_inc);
                if (!bm_rd_bit) begin
                    buf_wr_en                 = 1'b1;
                    buf_wr_item.frame_valid   = 1'b1;
                    buf_wr_item.is_retransmit = 1'b1;
                    buf_wr_item.frame_seq     = SEQ_W'(cur_reg);
                    n_next                    = n_reg + NW'(1);
                end
                state_next = ST_TO_RD;
            end
            ST_SEND_SETUP: begin
                // New frames stop at the window edge, at the total or when the buffer is full.
                if (win_sum < SUM_W'(tot_eff)) begin
                    lim_next = CNT_W'(win_sum);
                end else begin
                    lim_next = tot_eff;
                end
                state_next = ST_SEND;
            end
            ST_SEND: begin
                unit_a = UW'(next_reg);
                unit_b = UW'(lim_reg);
                if (unit_lt && !n_full) begin
                    buf_wr_en                 = 1'b1;
                    buf_wr_item.frame_valid   = 1'b1;
                    buf_wr_item.is_retransmit = 1'b0;
                    buf_wr_item.frame_seq     = SEQ_W'(next_reg);
                    n_next                    = n_reg + NW'(1);
                    next_next                 = CNT_W'(unit_inc);
                end else begin
                    if (n_reg == '0) begin
                        // Nothing sent: a lone status item closes the event.
                        buf_wr_en = 1'b1;
                        n_next    = NW'(1);
                    end
                    done_next   = !(base_reg < tot_eff);
                    rd_idx_next = '0;
                    state_next  = ST_DRAIN_RD;
                end
            end
            ST_DRAIN_RD: begin
                state_next = ST_DRAIN_LD;
            end
            ST_DRAIN_LD: begin
                if (m_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = buf_rd_item;
                    m_last_next  = (rd_idx_reg + NW'(1)) == n_reg;
                    m_done_next  = done_reg;
                    m_ign_next   = ignored_reg;
                    rd_idx_next  = rd_idx_reg + NW'(1);
                    if ((rd_idx_reg + NW'(1)) == n_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DRAIN_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_seq     = m_item_reg.frame_seq;
    assign m_frame_valid   = m_item_reg.frame_valid;
    assign m_is_retransmit = m_item_reg.is_retransmit;
    assign m_last          = m_last_reg;
    assign m_all_done      = m_done_reg;
    assign m_ack_ignored   = m_ign_reg;

    // The window base never passes the next frame to be sent.
    a_base_le_next: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg <= next_reg)
        else $error("window base passed next frame to send");

    // A status item carries no frame and always closes its event.
    a_status_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_valid) |-> (m_last && !m_is_retransmit && m_frame_seq == '0))
        else $error("malformed status item");

    // The item count never exceeds the buffer depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(MAX_WINDOW))
        else $error("item buffer overrun");

    // A new frame advances next_to_send by exactly one.
    a_send_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND && buf_wr_en && buf_wr_item.frame_valid)
            |=> (next_reg == $past(next_reg) + CNT_W'(1)))
        else $error("next frame counter did not step");

endmodule
`default_nettype wire
